// ----- rtl/round_robin_id_allocator_macros.svh -----
// Assertion macros for the round-robin identifier allocator checker.
// Each macro samples on the rising edge of clock; some are disabled during reset.
`ifndef ROUND_ROBIN_ID_ALLOCATOR_MACROS_SVH
`define ROUND_ROBIN_ID_ALLOCATOR_MACROS_SVH

// Same-cycle implication, also checked while reset is high.
`define RRIA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// Next-cycle implication, ignored while reset is high.
`define RRIA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

// Next-cycle implication, also checked while reset is high.
`define RRIA_ASSERT_NEXT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

// ----- rtl/rria_pkg.sv -----
// Shared types and constants for the round-robin identifier allocator.
// Used by rria_map_ram and round_robin_id_allocator; depends on nothing.
`default_nettype none

package rria_pkg;

   // Default identifier width; identifiers 1 to 2^ID_BITS-1 are handed out.
   localparam int RRIA_ID_BITS_DEFAULT = 8;

   // Fixed widths of the transaction fields.
   localparam int RRIA_FIELD_BITS = 8;
   localparam int RRIA_OP_BITS    = 2;

   typedef enum logic [RRIA_OP_BITS-1:0] {
      OP_ALLOC        = 2'd0,
      OP_RELEASE_ID   = 2'd1,
      OP_RELEASE_LAST = 2'd2,
      OP_QUERY        = 2'd3
   } rria_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_FINISH
   } rria_state_type;

   // Control of the allocation map port.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_data;
   } rria_ram_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/rria_map_ram.sv -----
// Single-port bit map of allocated identifiers with a registered read.
// Depends on rria_pkg for the port control struct.
`default_nettype none

module rria_map_ram #(
   parameter int ADDR_BITS = rria_pkg::RRIA_ID_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic [ADDR_BITS-1:0]      addr,
   input  wire rria_pkg::rria_ram_ctl_type ctl,
   output logic                           rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic mem [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/round_robin_id_allocator.sv -----
// Round-robin identifier allocator: sequencer, state registers and result register.
// Depends on rria_pkg and instantiates rria_map_ram for the allocation map.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_operation[1:0], req_id[7:0]
//   rsp_      out        rsp_valid/rsp_stall  rsp_result_id[7:0], rsp_ok
//
// After reset the map is cleared one entry per cycle, all 2^ID_BITS entries;
// req_stall stays high during that pass.
// An allocate transaction probes map entries one per cycle through the single
// map port, at most 2^ID_BITS-1 of them, and then finishes.
// Release, release-last and query go through a map lookup; a request that needs no
// map lookup goes straight to the finish state. One transaction is in flight at a time.
// A finished result waits in the rsp_ register while rsp_stall is high, and the
// next request may be accepted during that wait.
`default_nettype none

module round_robin_id_allocator #(
   parameter int ID_BITS = rria_pkg::RRIA_ID_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [rria_pkg::RRIA_OP_BITS-1:0]    req_operation,
   input  wire logic [rria_pkg::RRIA_FIELD_BITS-1:0] req_id,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [rria_pkg::RRIA_FIELD_BITS-1:0]      rsp_result_id,
   output logic                                     rsp_ok
);

   localparam int FIELD_BITS = rria_pkg::RRIA_FIELD_BITS;

   // The highest identifier; also the largest number that can be allocated.
   localparam logic [ID_BITS-1:0] ID_MAX = '1;
   localparam logic [ID_BITS-1:0] ID_ONE = {{(ID_BITS-1){1'b0}}, 1'b1};

   // The search steps forward and wraps from the highest identifier back to 1,
   // so identifier 0 is never probed.
   function automatic logic [ID_BITS-1:0] next_pos(input logic [ID_BITS-1:0] p);
      return (p == ID_MAX) ? ID_ONE : p + ID_ONE;
   endfunction

   // Fit an identifier into the result field (zero extend or truncate).
   function automatic logic [FIELD_BITS-1:0] to_field(input logic [ID_BITS-1:0] v);
      logic [ID_BITS+FIELD_BITS-1:0] t;
      t = {{FIELD_BITS{1'b0}}, v};
      return t[FIELD_BITS-1:0];
   endfunction

   // Reduce the requested identifier to the map's address width.
   function automatic logic [ID_BITS-1:0] to_key(input logic [FIELD_BITS-1:0] v);
      logic [ID_BITS+FIELD_BITS-1:0] t;
      t = {{ID_BITS{1'b0}}, v};
      return t[ID_BITS-1:0];
   endfunction

   // Control state.
   rria_pkg::rria_state_type state_ff, state_in;
   logic [ID_BITS-1:0]       clr_addr_ff, clr_addr_in;
   logic [ID_BITS-1:0]       search_ff, search_in;
   logic [ID_BITS-1:0]       count_ff, count_in;
   logic [ID_BITS-1:0]       recent_ff, recent_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Per-transaction working registers.
   rria_pkg::rria_op_type    op_ff, op_in;
   logic [ID_BITS-1:0]       key_ff, key_in;
   logic [ID_BITS-1:0]       probe_ff, probe_in;
   logic [FIELD_BITS-1:0]    res_id_ff, res_id_in;
   logic                     res_ok_ff, res_ok_in;
   logic [FIELD_BITS-1:0]    rsp_result_id_ff, rsp_result_id_in;
   logic                     rsp_ok_ff, rsp_ok_in;

   // Map port.
   logic [ID_BITS-1:0]         ram_addr;
   rria_pkg::rria_ram_ctl_type ram_ctl;
   logic                       ram_rd_data;

   logic               accept;
   logic               rsp_load;
   logic [ID_BITS-1:0] start_pos;
   logic [ID_BITS-1:0] scan_next;
   logic [ID_BITS-1:0] req_key;

   rria_map_ram #(
      .ADDR_BITS(ID_BITS)
   ) u_map (
      .clock  (clock),
      .addr   (ram_addr),
      .ctl    (ram_ctl),
      .rd_data(ram_rd_data)
   );

   assign req_stall = (state_ff != rria_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_load  = (state_ff == rria_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign start_pos = next_pos(search_ff);
   assign scan_next = next_pos(probe_ff);
   assign req_key   = to_key(req_id);

   // Sequencer: clear pass, request decode, map lookup, forward scan, result hand-off.
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      search_in   = search_ff;
      count_in    = count_ff;
      recent_in   = recent_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      probe_in    = probe_ff;
      res_id_in   = res_id_ff;
      res_ok_in   = res_ok_ff;
      ram_addr    = key_ff;
      ram_ctl     = '0;

      case (state_ff)
         rria_pkg::ST_CLEAR: begin
            ram_addr        = clr_addr_ff;
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_data = 1'b0;
            clr_addr_in     = clr_addr_ff + ID_ONE;
            if (clr_addr_ff == ID_MAX) begin
               state_in = rria_pkg::ST_IDLE;
            end
         end

         rria_pkg::ST_IDLE: begin
            if (accept) begin
               op_in     = rria_pkg::rria_op_type'(req_operation);
               key_in    = req_key;
               res_id_in = req_id;
               res_ok_in = 1'b0;
               case (rria_pkg::rria_op_type'(req_operation))
                  rria_pkg::OP_ALLOC: begin
                     res_id_in = '0;
                     if (count_ff == ID_MAX) begin
                        // Every identifier is in use: fail without scanning.
                        state_in = rria_pkg::ST_FINISH;
                     end else begin
                        probe_in      = start_pos;
                        ram_addr      = start_pos;
                        ram_ctl.rd_en = 1'b1;
                        state_in      = rria_pkg::ST_SCAN;
                     end
                  end
                  rria_pkg::OP_RELEASE_LAST: begin
                     key_in    = recent_ff;
                     res_id_in = to_field(recent_ff);
                     if (recent_ff == '0) begin
                        state_in = rria_pkg::ST_FINISH;
                     end else begin
                        ram_addr      = recent_ff;
                        ram_ctl.rd_en = 1'b1;
                        state_in      = rria_pkg::ST_LOOKUP;
                     end
                  end
                  default: begin
                     // Release of a given identifier and query both look the key up.
                     if (req_key == '0) begin
                        state_in = rria_pkg::ST_FINISH;
                     end else begin
                        ram_addr      = req_key;
                        ram_ctl.rd_en = 1'b1;
                        state_in      = rria_pkg::ST_LOOKUP;
                     end
                  end
               endcase
            end
         end

         rria_pkg::ST_LOOKUP: begin
            ram_addr = key_ff;
            state_in = rria_pkg::ST_FINISH;
            if (ram_rd_data) begin
               res_ok_in = 1'b1;
               case (op_ff)
                  rria_pkg::OP_RELEASE_ID: begin
                     ram_ctl.wr_en   = 1'b1;
                     ram_ctl.wr_data = 1'b0;
                     count_in        = count_ff - ID_ONE;
                  end
                  rria_pkg::OP_RELEASE_LAST: begin
                     ram_ctl.wr_en   = 1'b1;
                     ram_ctl.wr_data = 1'b0;
                     count_in        = count_ff - ID_ONE;
                     recent_in       = '0;
                  end
                  default: begin
                     // Query only reports the bit.
                  end
               endcase
            end
         end

         rria_pkg::ST_SCAN: begin
            // The read data belongs to probe_ff. Since the count is below the
            // maximum, a free entry is always found before the scan comes around.
            if (!ram_rd_data) begin
               ram_addr        = probe_ff;
               ram_ctl.wr_en   = 1'b1;
               ram_ctl.wr_data = 1'b1;
               count_in        = count_ff + ID_ONE;
               search_in       = probe_ff;
               recent_in       = probe_ff;
               res_id_in       = to_field(probe_ff);
               res_ok_in       = 1'b1;
               state_in        = rria_pkg::ST_FINISH;
            end else begin
               ram_addr      = scan_next;
               ram_ctl.rd_en = 1'b1;
               probe_in      = scan_next;
            end
         end

         rria_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = rria_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rria_pkg::ST_IDLE;
         end
      endcase
   end

   // Result register: loads when the finished transaction can move out.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_result_id_in = rsp_result_id_ff;
      rsp_ok_in        = rsp_ok_ff;
      if (rsp_load) begin
         rsp_valid_in     = 1'b1;
         rsp_result_id_in = res_id_ff;
         rsp_ok_in        = res_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rria_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         search_ff    <= '0;
         count_ff     <= '0;
         recent_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         search_ff    <= search_in;
         count_ff     <= count_in;
         recent_ff    <= recent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      key_ff           <= key_in;
      probe_ff         <= probe_in;
      res_id_ff        <= res_id_in;
      res_ok_ff        <= res_ok_in;
      rsp_result_id_ff <= rsp_result_id_in;
      rsp_ok_ff        <= rsp_ok_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_id = rsp_result_id_ff;
   assign rsp_ok        = rsp_ok_ff;

endmodule

`default_nettype wire

// ----- rtl/rria_checker.sv -----
// Port-level checker for the round-robin identifier allocator, bound to the top level.
// Depends on round_robin_id_allocator_macros.svh and rria_pkg for field widths.
`default_nettype none

`include "round_robin_id_allocator_macros.svh"

module rria_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [rria_pkg::RRIA_FIELD_BITS-1:0] rsp_result_id,
   input wire logic                                rsp_ok
);

   // No result is pending right after reset.
   `RRIA_ASSERT_NEXT_RST(a_reset_clears_rsp, reset, !rsp_valid)

   // The map clear pass holds off requests as reset is released.
   `RRIA_ASSERT_NOW(a_clear_blocks_req, $fell(reset), req_stall)

   // Only one transaction is in flight: accepting one makes the block busy.
   `RRIA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // An accepted request passes through at least one more state before its result is
   // loaded, so no new result appears in the cycle right after an acceptance.
   `RRIA_ASSERT_NEXT(a_no_instant_rsp, req_valid && !req_stall, !$rose(rsp_valid))

   // A stalled result holds.
   `RRIA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_result_id) && $stable(rsp_ok))

endmodule

bind round_robin_id_allocator rria_checker u_rria_checker (.*);

`default_nettype wire

// ----- tb/round_robin_id_allocator_tb.sv -----
// Self-checking testbench for round_robin_id_allocator: a ledger class predicts every reply.
// Depends on rria_pkg and the allocator RTL with its map RAM; needs no files or arguments.
`default_nettype none

module round_robin_id_allocator_tb;

   localparam int ID_BITS    = rria_pkg::RRIA_ID_BITS_DEFAULT;
   localparam int FIELD_BITS = rria_pkg::RRIA_FIELD_BITS;
   localparam int ID_SPACE   = 1 << ID_BITS;
   localparam int ID_MAX     = ID_SPACE - 1;
   // Slowest legal gap between two accepted transactions: the clearing pass after
   // reset or a full-map allocate scan, stretched by random stalls. Taken many times over.
   localparam int HANG_LIMIT = 4000;
   localparam int PHASES     = 6;
   localparam int PHASE_LEN  = 325;

   // The ledger mirrors the allocator's state and keeps the replies still owed.
   class id_ledger;
      typedef struct packed {
         logic [rria_pkg::RRIA_FIELD_BITS-1:0] result_id;
         logic                                 ok;
      } id_reply_type;

      bit                   id_taken[ID_SPACE];
      logic [ID_BITS-1:0]   cursor = '0;
      int unsigned          taken_count;
      logic [ID_BITS-1:0]   last_granted = '0;
      id_reply_type         replies_due[$];
      int unsigned          errors, replies_seen;
      int unsigned          grants, refusals, releases, query_hits;

      function void log_request(rria_pkg::rria_op_type op,
                                logic [rria_pkg::RRIA_FIELD_BITS-1:0] id);
         id_reply_type       r;
         logic [ID_BITS-1:0] key;
         logic [ID_BITS-1:0] p;
         bit                 found;
         key = id[ID_BITS-1:0];
         r.result_id = id;
         r.ok = 1'b0;
         case (op)
            rria_pkg::OP_ALLOC: begin
               r.result_id = '0;
               found = 1'b0;
               if (taken_count < ID_MAX) begin
                  p = cursor;
                  for (int n = 0; n < ID_MAX && !found; n++) begin
                     p = (p == ID_BITS'(ID_MAX)) ? ID_BITS'(1) : p + ID_BITS'(1);
                     if (!id_taken[p]) begin
                        found = 1'b1;
                        id_taken[p] = 1'b1;
                        taken_count++;
                        cursor = p;
                        last_granted = p;
                        r.result_id = p;
                        r.ok = 1'b1;
                     end
                  end
               end
               if (found) grants++;
               else refusals++;
            end
            rria_pkg::OP_RELEASE_ID: begin
               if (key != 0 && id_taken[key]) begin
                  id_taken[key] = 1'b0;
                  if (taken_count > 0) taken_count--;
                  r.ok = 1'b1;
                  releases++;
               end
            end
            rria_pkg::OP_RELEASE_LAST: begin
               // Only the single most recent grant can be returned this way, and only once.
               r.result_id = last_granted;
               if (last_granted != 0 && id_taken[last_granted]) begin
                  id_taken[last_granted] = 1'b0;
                  if (taken_count > 0) taken_count--;
                  last_granted = '0;
                  r.ok = 1'b1;
                  releases++;
               end
            end
            default: begin
               if (key != 0 && id_taken[key]) begin
                  r.ok = 1'b1;
                  query_hits++;
               end
            end
         endcase
         replies_due.push_back(r);
      endfunction

      function void check_reply(logic [rria_pkg::RRIA_FIELD_BITS-1:0] result_id, logic ok);
         id_reply_type e;
         replies_seen++;
         if (replies_due.size() == 0) begin
            $error("reply with nothing outstanding: result_id %0d ok %0b", result_id, ok);
            errors++;
            return;
         end
         e = replies_due.pop_front();
         if (result_id !== e.result_id) begin
            $error("result_id: expected %0d, actual %0d", e.result_id, result_id);
            errors++;
         end
         if (ok !== e.ok) begin
            $error("ok: expected %0b, actual %0b", e.ok, ok);
            errors++;
         end
      endfunction

      // Finds an identifier that is currently handed out, starting at a random spot.
      function logic [rria_pkg::RRIA_FIELD_BITS-1:0] pick_taken_id();
         int unsigned start;
         int unsigned k;
         start = $urandom_range(ID_MAX);
         for (int i = 0; i < ID_SPACE; i++) begin
            k = (start + i) % ID_SPACE;
            if (id_taken[k]) return FIELD_BITS'(k);
         end
         return FIELD_BITS'(start);
      endfunction

      function int unsigned outstanding();
         return replies_due.size();
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   rria_pkg::rria_op_type                req_operation = rria_pkg::OP_QUERY;
   logic [rria_pkg::RRIA_FIELD_BITS-1:0] req_id = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [rria_pkg::RRIA_FIELD_BITS-1:0] rsp_result_id;
   logic                                 rsp_ok;

   id_ledger    ledger = new;
   // While steady is set neither side inserts idle cycles.
   bit          steady = 1'b0;
   int unsigned hang_count = 0;

   round_robin_id_allocator #(
      .ID_BITS(ID_BITS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_operation(req_operation),
      .req_id       (req_id),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result_id(rsp_result_id),
      .rsp_ok       (rsp_ok)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Reply side: a transaction is taken at every edge with valid high and stall low.
   // All signals are sampled at the edge before any nonblocking update lands, and
   // the stall for the next cycle is rolled fresh each cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         ledger.check_reply(rsp_result_id, rsp_ok);
      rsp_stall <= !steady && ($urandom_range(99) < 18);
   end

   // Watchdog: counts cycles in which neither channel moves a transaction. The count
   // starts after reset, so the clearing pass of the map is covered by the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
         $display("round_robin_id_allocator regression: fail");
         $finish;
      end else begin
         hang_count <= hang_count + 1;
      end
   end

   // Presents one request, with a random idle gap in front of it unless the run is
   // steady, and holds it until the allocator accepts it. Valid stays high on return
   // so back-to-back requests need no extra cycle.
   task automatic send_request(input rria_pkg::rria_op_type op,
                               input logic [rria_pkg::RRIA_FIELD_BITS-1:0] id);
      while (!steady && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_id        <= id;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      ledger.log_request(op, id);
   endtask

   // Holds the request side quiet until every owed reply has come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.outstanding() != 0)
         @(posedge clock);
   endtask

   // One random request. Filling phases lean on allocate so the map reaches full and
   // the search wraps; emptying phases lean on releases of identifiers that are really
   // held. Releases by id and queries mostly aim at held identifiers, the rest are random.
   task automatic send_random(input bit filling);
      int unsigned                          roll;
      rria_pkg::rria_op_type                op;
      logic [rria_pkg::RRIA_FIELD_BITS-1:0] id;
      roll = $urandom_range(99);
      id   = FIELD_BITS'($urandom_range(ID_MAX));
      if (filling) begin
         if (roll < 75)      op = rria_pkg::OP_ALLOC;
         else if (roll < 83) op = rria_pkg::OP_RELEASE_ID;
         else if (roll < 88) op = rria_pkg::OP_RELEASE_LAST;
         else                op = rria_pkg::OP_QUERY;
      end else begin
         if (roll < 8)       op = rria_pkg::OP_ALLOC;
         else if (roll < 78) op = rria_pkg::OP_RELEASE_ID;
         else if (roll < 85) op = rria_pkg::OP_RELEASE_LAST;
         else                op = rria_pkg::OP_QUERY;
      end
      if ((op == rria_pkg::OP_RELEASE_ID || op == rria_pkg::OP_QUERY) &&
          $urandom_range(99) < 70)
         id = ledger.pick_taken_id();
      send_request(op, id);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. Identifier zero is never valid, release-last with nothing
      // granted since reset fails, and the id field is ignored by allocate.
      send_request(rria_pkg::OP_QUERY, 8'h00);
      send_request(rria_pkg::OP_RELEASE_ID, 8'h00);
      send_request(rria_pkg::OP_RELEASE_LAST, 8'hFF);
      send_request(rria_pkg::OP_ALLOC, 8'hFF);
      send_request(rria_pkg::OP_ALLOC, 8'h00);
      send_request(rria_pkg::OP_QUERY, 8'h01);
      send_request(rria_pkg::OP_QUERY, 8'hFF);
      // A successful release-last forgets the grant, so a second one fails.
      send_request(rria_pkg::OP_RELEASE_LAST, 8'h00);
      send_request(rria_pkg::OP_RELEASE_LAST, 8'h00);
      // The search resumes after the last grant rather than at the lowest free id.
      send_request(rria_pkg::OP_ALLOC, 8'h55);
      // Release-last of a grant already freed by id fails but still echoes the id.
      send_request(rria_pkg::OP_RELEASE_ID, 8'h03);
      send_request(rria_pkg::OP_RELEASE_LAST, 8'h00);
      send_request(rria_pkg::OP_RELEASE_ID, 8'h01);
      send_request(rria_pkg::OP_RELEASE_ID, 8'h01);
      send_request(rria_pkg::OP_QUERY, 8'hAA);
      drain_replies();

      // Random part: alternating fill and empty phases. The third phase runs with no
      // idle cycles on either side, and every phase ends with the sender paused until
      // the allocator has answered everything.
      for (int ph = 0; ph < PHASES; ph++) begin
         steady = (ph == 2);
         for (int i = 0; i < PHASE_LEN; i++)
            send_random(ph % 2 == 0);
         drain_replies();
      end
      steady = 1'b0;

      // Quiet tail, longer than the slowest allocate, to catch any stray reply.
      repeat (ID_SPACE + 8) @(posedge clock);
      if (ledger.outstanding() != 0) begin
         $error("%0d replies never arrived", ledger.outstanding());
         ledger.errors++;
      end

      $display("Checked %0d replies: %0d grants, %0d refused on a full map, %0d releases,",
               ledger.replies_seen, ledger.grants, ledger.refusals, ledger.releases);
      $display("%0d query hits, with the search wrapping and random stalls on both sides.",
               ledger.query_hits);
      if (ledger.errors == 0) begin
         $display("round_robin_id_allocator regression: pass");
      end else begin
         $display("round_robin_id_allocator regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
